### sv/imdmse_pkg.sv
// shared constants, types and codes for the image mse compare block
`timescale 1ns / 1ps

package imdmse_pkg;

   // image and component limits
   localparam int COMPONENTS = 3;
   localparam int LANES      = 3;
   localparam int USED_LANES = (COMPONENTS < LANES) ? COMPONENTS : LANES;
   localparam int MAX_PIXELS = 1048576;

   // widths
   localparam int COMP_W  = 16;
   localparam int SQ_W    = 2 * COMP_W;
   localparam int COUNT_W = 21;
   localparam int SUM_W   = 38;
   localparam int SSD_W   = 54;
   localparam int NUM_W   = 54;
   localparam int DEN_W   = 38;
   localparam int RES_W   = 32;
   localparam int STEP_W  = 6;
   localparam int FRAC_W  = 16;

   // register map of the csr channel
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_DELTA_THR = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MSE_THR   = 8'd1;

   // request into the shared divider
   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] numer;
      logic [DEN_W-1:0] denom;
      logic [RES_W-1:0] thresh;
   } div_req_type;

   // answer from the shared divider
   typedef struct packed {
      logic             done;
      logic [RES_W-1:0] quot;
      logic             above;
   } div_rsp_type;

endpackage

### sv/image_difference_mse_compare.sv
// Image pair compare: per-pixel differences plus mean, delta and mse per image.
// An ordinary pixel gives its registered result in the cycle after its transfer, one per cycle
// while the result channel does not stall. A last pixel runs four divisions on one shared
// 1-bit-per-cycle divider (54 steps each), only three when the delta needs no division,
// and its result follows the last division; no pixel is taken meanwhile.
// Reset (synchronous, active high) clears the sums, the count, both thresholds and the output valid.
`timescale 1ns / 1ps

module image_difference_mse_compare (
   input  logic         clock,
   input  logic         reset,
   // pixel pair channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // first_red, first_green, first_blue, second_red, second_green, second_blue
   input  logic [95:0]  req_tdata,
   input  logic         req_tlast,
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // diff_red, diff_green, diff_blue, average_first, average_second,
   // relative_delta, mean_squared_error
   output logic [143:0] rsp_tdata,
   // stats_valid, images_differ
   output logic [1:0]   rsp_tuser,
   // register writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [imdmse_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]  csr_data
);
   import imdmse_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;

   localparam logic [1:0] OP_AVG1  = 2'd0;
   localparam logic [1:0] OP_AVG2  = 2'd1;
   localparam logic [1:0] OP_MSE   = 2'd2;
   localparam logic [1:0] OP_DELTA = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [RES_W-1:0]      delta_thr_ff, delta_thr_in;
   logic [RES_W-1:0]      mse_thr_ff, mse_thr_in;
   logic [SUM_W-1:0]      sum_first_ff, sum_first_in;
   logic [SUM_W-1:0]      sum_second_ff, sum_second_in;
   logic [SSD_W-1:0]      ssd_ff, ssd_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [3*COMP_W-1:0]   diff_ff, diff_in;
   logic [COMP_W-1:0]     avg1_ff, avg1_in, avg2_ff, avg2_in;
   logic [RES_W-1:0]      mse_ff, mse_in;
   logic                  mse_above_ff, mse_above_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [143:0]          rsp_data_ff, rsp_data_in;
   logic [1:0]            rsp_user_ff, rsp_user_in;

   logic [COMP_W-1:0]     first_comp [LANES];
   logic [COMP_W-1:0]     second_comp[LANES];
   logic [COMP_W-1:0]     lane_diff  [LANES];
   logic [SQ_W-1:0]       lane_sq    [LANES];
   logic [3*COMP_W-1:0]   pix_diff;
   logic [SUM_W-1:0]      add_first, add_second;
   logic [SSD_W-1:0]      add_ssd;
   logic                  req_fire, rsp_fire, csr_fire;
   logic [DEN_W-1:0]      pix_denom;
   logic [SUM_W-1:0]      sum_gap, sum_small;
   logic                  finish;
   logic [RES_W-1:0]      delta_val;
   logic                  delta_above;
   logic                  differ;
   div_req_type           div_req;
   div_rsp_type           div_rsp;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);

   // component lanes
   for (genvar g = 0; g < LANES; g++) begin : g_lane
      assign first_comp[g]  = req_tdata[g*COMP_W +: COMP_W];
      assign second_comp[g] = req_tdata[(LANES+g)*COMP_W +: COMP_W];
      imdmse_lane u_lane (
         .first_comp  (first_comp[g]),
         .second_comp (second_comp[g]),
         .abs_diff    (lane_diff[g]),
         .sq_diff     (lane_sq[g])
      );
      assign pix_diff[g*COMP_W +: COMP_W] = lane_diff[g];
   end

   // merge what the used lanes found
   always_comb begin
      add_first  = '0;
      add_second = '0;
      add_ssd    = '0;
      for (int i = 0; i < USED_LANES; i++) begin
         add_first  = add_first  + SUM_W'(first_comp[i]);
         add_second = add_second + SUM_W'(second_comp[i]);
         add_ssd    = add_ssd    + SSD_W'(lane_sq[i]);
      end
   end

   // end-of-image operands
   assign pix_denom = DEN_W'(count_ff) * DEN_W'(COMPONENTS);
   assign sum_gap   = (sum_first_ff > sum_second_ff) ? (sum_first_ff - sum_second_ff)
                                                     : (sum_second_ff - sum_first_ff);
   assign sum_small = (sum_first_ff < sum_second_ff) ? sum_first_ff : sum_second_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      delta_thr_in  = delta_thr_ff;
      mse_thr_in    = mse_thr_ff;
      sum_first_in  = sum_first_ff;
      sum_second_in = sum_second_ff;
      ssd_in        = ssd_ff;
      count_in      = count_ff;
      diff_in       = diff_ff;
      avg1_in       = avg1_ff;
      avg2_in       = avg2_ff;
      mse_in        = mse_ff;
      mse_above_in  = mse_above_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_fire;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      div_req       = '0;
      finish        = 1'b0;
      delta_val     = '0;
      delta_above   = 1'b0;

      // register writes
      if (csr_fire) begin
         unique case (csr_index)
            CSR_DELTA_THR: delta_thr_in = csr_data;
            CSR_MSE_THR:   mse_thr_in   = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (count_ff < COUNT_W'(MAX_PIXELS)) begin
                  sum_first_in  = sum_first_ff + add_first;
                  sum_second_in = sum_second_ff + add_second;
                  ssd_in        = ssd_ff + add_ssd;
                  count_in      = count_ff + 1'b1;
               end
               if (req_tlast) begin
                  diff_in  = pix_diff;
                  op_in    = OP_AVG1;
                  state_in = ST_START;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = {96'd0, pix_diff};
                  rsp_user_in  = 2'b00;
               end
            end
         end
         ST_START: begin
            div_req.denom  = pix_denom;
            div_req.thresh = '0;
            unique case (op_ff)
               OP_AVG1: div_req.numer = NUM_W'(sum_first_ff);
               OP_AVG2: div_req.numer = NUM_W'(sum_second_ff);
               OP_MSE: begin
                  div_req.numer  = NUM_W'(ssd_ff);
                  div_req.thresh = mse_thr_ff;
               end
               OP_DELTA: begin
                  div_req.numer  = NUM_W'(sum_gap) << FRAC_W;
                  div_req.denom  = sum_small;
                  div_req.thresh = delta_thr_ff;
               end
               default: ;
            endcase
            // equal sums or a zero smaller sum need no division
            if (op_ff == OP_DELTA && sum_gap == '0) begin
               finish = 1'b1;
            end else if (op_ff == OP_DELTA && sum_small == '0) begin
               finish      = 1'b1;
               delta_val   = '1;
               delta_above = 1'b1;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_rsp.done) begin
               unique case (op_ff)
                  OP_AVG1: avg1_in = div_rsp.quot[COMP_W-1:0];
                  OP_AVG2: avg2_in = div_rsp.quot[COMP_W-1:0];
                  OP_MSE: begin
                     mse_in       = div_rsp.quot;
                     mse_above_in = div_rsp.above;
                  end
                  OP_DELTA: begin
                     finish      = 1'b1;
                     delta_val   = div_rsp.quot;
                     delta_above = div_rsp.above;
                  end
                  default: ;
               endcase
               if (op_ff != OP_DELTA) begin
                  op_in    = op_ff + 1'b1;
                  state_in = ST_START;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // end of image: verdict, result and cleared sums
      differ = (((delta_thr_ff != '0) || (mse_thr_ff == '0)) && delta_above)
            || (((mse_thr_ff != '0) || (delta_thr_ff == '0)) && mse_above_ff);
      if (finish) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = {mse_ff, delta_val, avg2_ff, avg1_ff, diff_ff};
         rsp_user_in   = {differ, 1'b1};
         sum_first_in  = '0;
         sum_second_in = '0;
         ssd_in        = '0;
         count_in      = '0;
         state_in      = ST_IDLE;
      end
   end

   imdmse_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_AVG1;
         delta_thr_ff  <= '0;
         mse_thr_ff    <= '0;
         sum_first_ff  <= '0;
         sum_second_ff <= '0;
         ssd_ff        <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         delta_thr_ff  <= delta_thr_in;
         mse_thr_ff    <= mse_thr_in;
         sum_first_ff  <= sum_first_in;
         sum_second_ff <= sum_second_in;
         ssd_ff        <= ssd_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      diff_ff      <= diff_in;
      avg1_ff      <= avg1_in;
      avg2_ff      <= avg2_in;
      mse_ff       <= mse_in;
      mse_above_ff <= mse_above_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // pixel count never passes the image limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_PIXELS))
      else $error("pixel count above limit");

   // no result is pending while the divisions run
   a_no_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !rsp_valid_ff)
      else $error("result pending during divisions");

   // divider answers only while the sequencer waits for it
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_WAIT))
      else $error("divider done outside wait");

   // a finished image leaves cleared sums and a stats result
   a_clear_after: assert property (@(posedge clock) disable iff (reset)
      finish |=> (count_ff == '0) && (ssd_ff == '0) && rsp_valid_ff && rsp_user_ff[0])
      else $error("sums not cleared after image end");

endmodule

### sv/imdmse_lane.sv
// one component lane: absolute difference and its square
`timescale 1ns / 1ps

module imdmse_lane (
   input  logic [imdmse_pkg::COMP_W-1:0] first_comp,
   input  logic [imdmse_pkg::COMP_W-1:0] second_comp,
   output logic [imdmse_pkg::COMP_W-1:0] abs_diff,
   output logic [imdmse_pkg::SQ_W-1:0]   sq_diff
);
   import imdmse_pkg::*;

   // absolute difference
   assign abs_diff = (first_comp > second_comp) ? (first_comp - second_comp)
                                                : (second_comp - first_comp);

   // square of the difference
   assign sq_diff = SQ_W'(abs_diff) * SQ_W'(abs_diff);

endmodule

### sv/imdmse_div.sv
// shared restoring divider, one quotient bit per cycle, with threshold compare
`timescale 1ns / 1ps

module imdmse_div (
   input  logic                     clock,
   input  logic                     reset,
   input  imdmse_pkg::div_req_type  div_req,
   output imdmse_pkg::div_rsp_type  div_rsp
);
   import imdmse_pkg::*;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [NUM_W-1:0]  quot_ff, quot_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [RES_W-1:0]  thr_ff, thr_in;
   logic [DEN_W:0]    trial;
   logic              qbit;

   // one restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      thr_in  = thr_ff;
      trial   = {rem_ff, quot_ff[NUM_W-1]};
      qbit    = 1'b0;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quot_in = div_req.numer;
         rem_in  = '0;
         den_in  = div_req.denom;
         thr_in  = div_req.thresh;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            qbit   = 1'b1;
         end else begin
            rem_in = trial[DEN_W-1:0];
         end
         quot_in = {quot_ff[NUM_W-2:0], qbit};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      thr_ff  <= thr_in;
   end

   // saturated quotient and exact compare against the threshold
   always_comb begin
      div_rsp.done  = done_ff;
      div_rsp.quot  = (|quot_ff[NUM_W-1:RES_W]) ? '1 : quot_ff[RES_W-1:0];
      div_rsp.above = (|quot_ff[NUM_W-1:RES_W])
                   || (quot_ff[RES_W-1:0] > thr_ff)
                   || ((quot_ff[RES_W-1:0] == thr_ff) && (rem_ff != '0));
   end

endmodule

### test/testbench.sv
// testbench for the image pair mse compare block: scoreboard, stimulus and checks
`timescale 1ns / 1ps

module testbench;
   import imdmse_pkg::*;

   // one expected or observed result of the block
   typedef struct packed {
      logic [15:0] diff_red, diff_green, diff_blue;
      logic        stats_valid, images_differ;
      logic [15:0] average_first, average_second;
      logic [31:0] relative_delta, mean_squared_error;
   } pixel_result_type;

   // predicts the block and keeps results still due
   class mse_scoreboard;
      logic [31:0] delta_thr, mse_thr;
      logic [63:0] sum_first, sum_second, sum_sq, pixels;
      pixel_result_type pending[$];
      int errors;

      function void clear_all();
         delta_thr = 0; mse_thr = 0;
         sum_first = 0; sum_second = 0; sum_sq = 0; pixels = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
         if (idx == CSR_DELTA_THR) delta_thr = value;
         else if (idx == CSR_MSE_THR) mse_thr = value;
      endfunction

      // quotient saturated to 32 bits, flag when exact value exceeds limit
      function logic [31:0] div_sat(logic [63:0] n, logic [63:0] d, logic [31:0] lim,
                                    output bit above);
         logic [63:0] q, r;
         q = n / d;
         r = n % d;
         above = (q > lim) || (q == lim && r != 0);
         return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      endfunction

      function void note_pixel(logic [95:0] data, bit last);
         pixel_result_type res;
         logic [63:0] a[3], b[3], dd[3], num, diff, smaller;
         logic [31:0] q32;
         bit d_above, m_above, dummy;
         for (int c = 0; c < 3; c++) begin
            a[c] = data[16*c +: 16];
            b[c] = data[48 + 16*c +: 16];
            dd[c] = (a[c] > b[c]) ? a[c] - b[c] : b[c] - a[c];
         end
         res = '0;
         res.diff_red   = dd[0][15:0];
         res.diff_green = dd[1][15:0];
         res.diff_blue  = dd[2][15:0];
         if (pixels < MAX_PIXELS) begin
            for (int c = 0; c < USED_LANES; c++) begin
               sum_first += a[c];
               sum_second += b[c];
               sum_sq += dd[c] * dd[c];
            end
            pixels++;
         end
         if (last) begin
            num = pixels * COMPONENTS;
            diff = (sum_first > sum_second) ? sum_first - sum_second : sum_second - sum_first;
            smaller = (sum_first < sum_second) ? sum_first : sum_second;
            if (diff == 0) begin
               res.relative_delta = 0; d_above = 0;
            end else if (smaller == 0) begin
               res.relative_delta = 32'hFFFF_FFFF; d_above = 1;
            end else begin
               res.relative_delta = div_sat(diff << 16, smaller, delta_thr, d_above);
            end
            res.mean_squared_error = div_sat(sum_sq, num, mse_thr, m_above);
            res.stats_valid = 1;
            res.images_differ = ((delta_thr != 0 || mse_thr == 0) && d_above)
                             || ((mse_thr != 0 || delta_thr == 0) && m_above);
            q32 = div_sat(sum_first, num, 0, dummy);
            res.average_first  = q32[15:0];
            q32 = div_sat(sum_second, num, 0, dummy);
            res.average_second = q32[15:0];
            sum_first = 0; sum_second = 0; sum_sq = 0; pixels = 0;
         end
         pending.push_back(res);
      endfunction

      function void check_result(pixel_result_type got);
         pixel_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0, req_tlast = 0;
   logic [95:0]  req_tdata = 0;
   logic         req_tready;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [143:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [31:0]  csr_data = 0;

   mse_scoreboard board = new();
   int images_done = 0;
   bit long_ready_gaps = 0;
   int stall_left = 0;

   always #4 clock = ~clock;

   image_difference_mse_compare dut (.*);

   // mostly short gaps, a few long ones
   function int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1; csr_index <= idx; csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, value);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // valid stays up after a transfer so pixels can follow back to back
   task automatic send_pixel(logic [95:0] data, bit last, bit no_gap = 0);
      int g;
      g = no_gap ? 0 : gap_len();
      if (g != 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1; req_tdata <= data; req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      board.note_pixel(data, last);
      if (last) images_done++;
   endtask

   // stop sending, wait for all expected results, then settle
   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function logic [15:0] rand_comp();
      unique case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h1000;
         default: return 16'($urandom());
      endcase
   endfunction

   function logic [95:0] rand_pixel();
      logic [95:0] p;
      for (int i = 0; i < 6; i++) p[16*i +: 16] = rand_comp();
      if ($urandom_range(0, 4) == 0) p[95:48] = p[47:0];
      return p;
   endfunction

   // result side with random stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            pixel_result_type got;
            got.diff_red = rsp_tdata[15:0];
            got.diff_green = rsp_tdata[31:16];
            got.diff_blue = rsp_tdata[47:32];
            got.average_first = rsp_tdata[63:48];
            got.average_second = rsp_tdata[79:64];
            got.relative_delta = rsp_tdata[111:80];
            got.mean_squared_error = rsp_tdata[143:112];
            got.stats_valid = rsp_tuser[0];
            got.images_differ = rsp_tuser[1];
            board.check_result(got);
         end
         if (!long_ready_gaps) begin
            rsp_tready <= 1;
         end else if (stall_left != 0) begin
            rsp_tready <= 0;
            stall_left--;
         end else begin
            stall_left = gap_len();
            rsp_tready <= (stall_left == 0);
         end
      end
   end

   // stimulus
   initial begin
      logic [31:0] thr_sets[6][2];
      int sent, len;
      board.clear_all();
      thr_sets = '{'{0, 0}, '{32'hFFFF_FFFF, 0}, '{0, 32'hFFFF_FFFF},
                   '{32'h0000_8000, 32'h0100_0000}, '{32'h0001_0000, 0},
                   '{0, 32'h0004_0000}};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, equal images, zero smaller average
      write_csr(CSR_DELTA_THR, 0);
      write_csr(CSR_MSE_THR, 0);
      send_pixel({48'h0, 48'h0}, 1);
      send_pixel({48'h0, 48'hFFFF_FFFF_FFFF}, 1);
      send_pixel({48'hFFFF_FFFF_FFFF, 48'h0}, 0);
      send_pixel({48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF}, 1);
      send_pixel({48'h1234_5678_9ABC, 48'h1234_5678_9ABC}, 1);
      send_pixel({48'h1000_1000_1000, 48'h2000_2000_2000}, 0);
      send_pixel({48'h2000_2000_2000, 48'h1000_1000_1000}, 1);
      send_pixel({16'h0001, 32'h0, 48'h0}, 1);
      drain();
      write_csr(8'd7, 32'hDEAD_BEEF);
      send_pixel({48'h0, 48'h5555_AAAA_5555}, 0);
      send_pixel({48'hAAAA_5555_AAAA, 48'h0}, 1);
      drain();

      // random images per threshold setting
      long_ready_gaps = 1;
      sent = 0;
      for (int s = 0; sent < 1800; s++) begin
         if (s % 8 == 0) begin
            drain();
            if (s / 8 < 6) begin
               write_csr(CSR_DELTA_THR, thr_sets[s / 8][0]);
               write_csr(CSR_MSE_THR, thr_sets[s / 8][1]);
            end else begin
               write_csr(CSR_DELTA_THR, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 32'h30000));
               write_csr(CSR_MSE_THR, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 32'h4000000));
            end
         end
         len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 40);
         for (int i = 0; i < len; i++) begin
            send_pixel(rand_pixel(), i == len - 1, $urandom_range(0, 4) == 0);
            sent++;
         end
      end
      drain();
      $display("covered %0d random pixels and %0d images over several threshold settings,",
               sent, images_done);
      $display("including extreme components, equal images and a zero smaller average");
      if (board.errors == 0 && board.pending.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   // timeout
   initial begin
      #40000000;
      $display("testbench NOT OK");
      $finish;
   end
endmodule

### image_difference_mse_compare.f
sv/imdmse_pkg.sv
sv/imdmse_lane.sv
sv/imdmse_div.sv
sv/image_difference_mse_compare.sv
test/testbench.sv
